// ===== design/ial_pkg.sv =====
`timescale 1ns / 1ps

package ial_pkg;

    localparam int DATA_W        = 32;
    localparam int MODE_W        = 3;
    localparam int IDX_W         = 4;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 5;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_READ,
        OP_WRITE,
        OP_APPEND,
        OP_INSERT,
        OP_REMOVE
    } t_op;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
    } t_rsp;

endpackage

// ===== design/ial_chan_if.sv =====
`timescale 1ns / 1ps

interface ial_chan_if #(
    parameter type t_payload = logic
);

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== design/ial_front.sv =====
`timescale 1ns / 1ps

module ial_front #(
    parameter int  DEPTH = ial_pkg::DEPTH_DEF,
    parameter type t_cmd = logic
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ial_chan_if.sink    i_req,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_ready
);

    localparam int PW = $clog2(DEPTH);
    localparam int UW = $clog2(DEPTH + 1);
    localparam int CW = (UW > ial_pkg::COUNT_W) ? UW : ial_pkg::COUNT_W;

    logic [UW-1:0] r_used;
    logic [UW-1:0] n_used;
    logic [CW-1:0] idx_c;
    logic [CW-1:0] used_c;
    logic          in_range;
    logic          full;
    logic          accept;

    assign idx_c    = CW'(i_req.payload.index);
    assign used_c   = CW'(r_used);
    assign in_range = idx_c < used_c;
    assign full     = used_c >= CW'(DEPTH);

    always_comb begin
        n_used       = r_used;
        o_cmd        = '0;
        o_cmd.op     = ial_pkg::OP_NOP;
        o_cmd.pos    = PW'(i_req.payload.index);
        o_cmd.value  = i_req.payload.value;
        o_cmd.status = ial_pkg::STATUS_OK;
        unique case (i_req.payload.mode)
            ial_pkg::MODE_READ: begin
                if (in_range) o_cmd.op = ial_pkg::OP_READ;
                else          o_cmd.status = ial_pkg::STATUS_BAD_INDEX;
            end
            ial_pkg::MODE_WRITE: begin
                if (in_range) o_cmd.op = ial_pkg::OP_WRITE;
                else          o_cmd.status = ial_pkg::STATUS_BAD_INDEX;
            end
            ial_pkg::MODE_APPEND: begin
                if (full) begin
                    o_cmd.status = ial_pkg::STATUS_FULL;
                end else begin
                    o_cmd.op  = ial_pkg::OP_APPEND;
                    o_cmd.pos = PW'(r_used);
                    n_used    = r_used + UW'(1);
                end
            end
            ial_pkg::MODE_INSERT: begin
                if (idx_c > used_c) begin
                    o_cmd.status = ial_pkg::STATUS_BAD_INDEX;
                end else if (full) begin
                    o_cmd.status = ial_pkg::STATUS_FULL;
                end else begin
                    o_cmd.op = ial_pkg::OP_INSERT;
                    n_used   = r_used + UW'(1);
                end
            end
            ial_pkg::MODE_REMOVE: begin
                if (in_range) begin
                    o_cmd.op = ial_pkg::OP_REMOVE;
                    n_used   = r_used - UW'(1);
                end else begin
                    o_cmd.status = ial_pkg::STATUS_BAD_INDEX;
                end
            end
            default: ;
        endcase
        o_cmd.count = ial_pkg::COUNT_W'(n_used);
    end

    assign i_req.ready = i_cmd_ready;
    assign o_cmd_valid = i_req.valid;
    assign accept      = i_req.valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (accept) begin
            r_used <= n_used;
        end
    end

endmodule

// ===== design/ial_queue.sv =====
`timescale 1ns / 1ps

module ial_queue #(
    parameter type t_item = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_item i_in_item,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_item o_out_item,
    input  logic  i_out_ready
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_cnt;
    logic        push;
    logic        pop;

    assign o_in_ready  = r_cnt != 2'd2;
    assign o_out_valid = r_cnt != 2'd0;
    assign o_out_item  = r_mem[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/ial_back.sv =====
`timescale 1ns / 1ps

module ial_back #(
    parameter int  DEPTH     = ial_pkg::DEPTH_DEF,
    parameter int  WORD_BITS = ial_pkg::WORD_BITS_DEF,
    parameter type t_cmd     = logic
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_ready,
    ial_chan_if.source  o_rsp
);

    localparam int PW   = $clog2(DEPTH);
    localparam int RD_N = (DEPTH < (1 << ial_pkg::IDX_W)) ? DEPTH : (1 << ial_pkg::IDX_W);
    localparam int RD_W = $clog2(RD_N);

    typedef logic [WORD_BITS-1:0] t_word;

    t_word          r_cells [DEPTH];
    t_word          n_cells [DEPTH];
    t_word          rd_view [RD_N];
    t_word          wr_word;
    t_word          rd_word;
    logic           r_valid;
    ial_pkg::t_rsp  r_rsp;
    logic           pop;

    genvar g;
    generate
        for (g = 0; g < RD_N; g++) begin : g_rd
            assign rd_view[g] = r_cells[g];
        end
    endgenerate

    assign wr_word     = t_word'($unsigned(i_cmd.value));
    assign rd_word     = rd_view[i_cmd.pos[RD_W-1:0]];
    assign o_cmd_ready = !r_valid || o_rsp.ready;
    assign pop         = i_cmd_valid && o_cmd_ready;

    // every cell picks from itself, a neighbor or the new word
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_cells[i] = r_cells[i];
            unique case (i_cmd.op)
                ial_pkg::OP_WRITE: begin
                    if (PW'(i) == i_cmd.pos) n_cells[i] = wr_word;
                end
                ial_pkg::OP_APPEND, ial_pkg::OP_INSERT: begin
                    if (PW'(i) == i_cmd.pos) begin
                        n_cells[i] = wr_word;
                    end else if (i > 0 && PW'(i) > i_cmd.pos) begin
                        n_cells[i] = r_cells[(i > 0) ? i - 1 : 0];
                    end
                end
                ial_pkg::OP_REMOVE: begin
                    if (i < DEPTH - 1 && PW'(i) >= i_cmd.pos) begin
                        n_cells[i] = r_cells[(i < DEPTH - 1) ? i + 1 : i];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cells <= n_cells;
            r_rsp.status <= i_cmd.status;
            r_rsp.count  <= i_cmd.count;
            if (i_cmd.op == ial_pkg::OP_READ || i_cmd.op == ial_pkg::OP_REMOVE) begin
                r_rsp.data <= ial_pkg::DATA_W'($signed(rd_word));
            end else begin
                r_rsp.data <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_cmd_ready) begin
            r_valid <= i_cmd_valid;
        end
    end

    assign o_rsp.valid   = r_valid;
    assign o_rsp.payload = r_rsp;

endmodule

// ===== design/indexed_array_list_core.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Payload                      Beat when
// i_req    in   mode, index, value           valid && ready
// o_rsp    out  data, status, count          valid && ready
//
// One beat per cycle sustained: the front classifies and counts in the
// accepting cycle, the back shifts the whole cell row in a single update.
// A result passes through the queue, then the output register, before
// it is offered. Synchronous active-low reset empties the list and
// the queue; cell contents are not cleared. Either side may stall freely.

module indexed_array_list_core #(
    parameter int DEPTH     = ial_pkg::DEPTH_DEF,
    parameter int WORD_BITS = ial_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ial_chan_if.sink    i_req,
    ial_chan_if.source  o_rsp
);

    localparam int PW = $clog2(DEPTH);

    typedef struct packed {
        ial_pkg::t_op                      op;
        logic [PW-1:0]                     pos;
        logic signed [ial_pkg::DATA_W-1:0] value;
        logic [ial_pkg::STATUS_W-1:0]      status;
        logic [ial_pkg::COUNT_W-1:0]       count;
    } t_cmd;

    logic front_valid;
    t_cmd front_cmd;
    logic front_ready;
    logic back_valid;
    t_cmd back_cmd;
    logic back_ready;

    ial_front #(
        .DEPTH (DEPTH),
        .t_cmd (t_cmd)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (front_ready)
    );

    ial_queue #(
        .t_item (t_cmd)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (front_valid),
        .i_in_item   (front_cmd),
        .o_in_ready  (front_ready),
        .o_out_valid (back_valid),
        .o_out_item  (back_cmd),
        .i_out_ready (back_ready)
    );

    ial_back #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .t_cmd     (t_cmd)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (back_valid),
        .i_cmd       (back_cmd),
        .o_cmd_ready (back_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    typedef logic [ial_pkg::MODE_W-1:0]        t_mode;
    typedef logic [ial_pkg::IDX_W-1:0]         t_index;
    typedef logic signed [ial_pkg::DATA_W-1:0] t_word;

    localparam int LIST_DEPTH    = ial_pkg::DEPTH_DEF;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;

    localparam t_mode MODE_FIRST_UNUSED = ial_pkg::MODE_REMOVE + 1'b1;
    localparam t_mode MODE_LAST         = '1;

    localparam t_word WORD_MIN = {1'b1, {(ial_pkg::DATA_W-1){1'b0}}};
    localparam t_word WORD_MAX = {1'b0, {(ial_pkg::DATA_W-1){1'b1}}};

    logic i_clk = 1'b0;
    logic i_rst_n;

    ial_chan_if #(.t_payload(ial_pkg::t_req)) req_if ();
    ial_chan_if #(.t_payload(ial_pkg::t_rsp)) rsp_if ();

    indexed_array_list_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected list contents, updated on each request beat
    t_word list_words [LIST_DEPTH];
    int    list_len = 0;

    // stimulus side: length of the list as the queued requests will leave it
    int plan_len    = 0;
    int plan_target = LIST_DEPTH / 2;

    ial_pkg::t_req req_backlog [$];
    ial_pkg::t_rsp due_responses [$];

    int   send_gap_pct = 0;
    int   take_gap_pct = 0;
    int   fail_count   = 0;
    int   stall_cycles = 0;
    logic req_beat     = 1'b0;

    function automatic ial_pkg::t_rsp list_response(ial_pkg::t_req rq);
        ial_pkg::t_rsp rs;
        int            i;
        int            ix;
        ix        = int'(rq.index);
        rs.data   = '0;
        rs.status = ial_pkg::STATUS_OK;
        case (rq.mode)
            ial_pkg::MODE_READ: begin
                if (ix < list_len) rs.data = list_words[rq.index];
                else rs.status = ial_pkg::STATUS_BAD_INDEX;
            end
            ial_pkg::MODE_WRITE: begin
                if (ix < list_len) list_words[rq.index] = rq.value;
                else rs.status = ial_pkg::STATUS_BAD_INDEX;
            end
            ial_pkg::MODE_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    rs.status = ial_pkg::STATUS_FULL;
                end else begin
                    list_words[t_index'(list_len)] = rq.value;
                    list_len++;
                end
            end
            ial_pkg::MODE_INSERT: begin
                if (ix > list_len) begin
                    rs.status = ial_pkg::STATUS_BAD_INDEX;
                end else if (list_len >= LIST_DEPTH) begin
                    rs.status = ial_pkg::STATUS_FULL;
                end else begin
                    for (i = list_len; i > ix; i--) begin
                        list_words[t_index'(i)] = list_words[t_index'(i - 1)];
                    end
                    list_words[rq.index] = rq.value;
                    list_len++;
                end
            end
            ial_pkg::MODE_REMOVE: begin
                if (ix < list_len) begin
                    rs.data = list_words[rq.index];
                    for (i = ix; i + 1 < list_len; i++) begin
                        list_words[t_index'(i)] = list_words[t_index'(i + 1)];
                    end
                    list_len--;
                end else begin
                    rs.status = ial_pkg::STATUS_BAD_INDEX;
                end
            end
            default: ;
        endcase
        rs.count = list_len[ial_pkg::COUNT_W-1:0];
        return rs;
    endfunction

    task automatic queue_req(t_mode md, t_index ix, t_word val);
        ial_pkg::t_req rq;
        rq.mode  = md;
        rq.index = ix;
        rq.value = val;
        case (md)
            ial_pkg::MODE_APPEND: if (plan_len < LIST_DEPTH) plan_len++;
            ial_pkg::MODE_INSERT: if (int'(ix) <= plan_len && plan_len < LIST_DEPTH) plan_len++;
            ial_pkg::MODE_REMOVE: if (int'(ix) < plan_len) plan_len--;
            default: ;
        endcase
        req_backlog.push_back(rq);
    endtask

    // mostly in-range indices; fill level steered toward a moving target
    task automatic queue_random_phase(int n_items);
        int     made;
        int     r;
        int     hi;
        bit     grow;
        t_mode  md;
        t_index ix;
        t_word  val;
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(59) == 0) begin
                r = $urandom_range(3);
                plan_target = (r == 0) ? 0 : (r == 1) ? LIST_DEPTH : $urandom_range(LIST_DEPTH);
            end
            grow = (plan_len < plan_target) ||
                   (plan_len == plan_target && $urandom_range(1) == 1);
            r = $urandom_range(99);
            if (r < 3) begin
                md = t_mode'($urandom_range(MODE_LAST, MODE_FIRST_UNUSED));
            end else if (r < 33) begin
                md = $urandom_range(1) ? ial_pkg::MODE_READ : ial_pkg::MODE_WRITE;
            end else begin
                if (r >= 90) grow = !grow;
                if (grow) md = $urandom_range(1) ? ial_pkg::MODE_APPEND : ial_pkg::MODE_INSERT;
                else md = ial_pkg::MODE_REMOVE;
            end
            if (md == ial_pkg::MODE_INSERT) begin
                hi = (plan_len < LIST_DEPTH) ? plan_len : LIST_DEPTH - 1;
            end else begin
                hi = plan_len - 1;
            end
            if (hi >= 0 && $urandom_range(99) < 85) ix = t_index'($urandom_range(hi));
            else ix = t_index'($urandom);
            case ($urandom_range(15))
                0:       val = WORD_MIN;
                1:       val = WORD_MAX;
                2:       val = '0;
                3:       val = '1;
                default: val = t_word'($urandom);
            endcase
            queue_req(md, ix, val);
            if (md <= ial_pkg::MODE_REMOVE) made++;
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (req_backlog.size() != 0 || req_if.valid || due_responses.size() != 0);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            rsp_if.ready <= 1'b0;
        end else begin
            if (!req_if.valid || req_beat) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    req_if.payload <= req_backlog.pop_front();
                    req_if.valid   <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= take_gap_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        ial_pkg::t_rsp want;
        ial_pkg::t_rsp got;
        req_beat <= req_if.valid && req_if.ready;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.payload;
                if (due_responses.size() == 0) begin
                    $display("%0t: unexpected response data %0d status %0d count %0d",
                             $time, got.data, got.status, got.count);
                    fail_count++;
                end else begin
                    want = due_responses.pop_front();
                    if (got.data !== want.data) begin
                        $display("%0t: data mismatch: expected %0d, actual %0d",
                                 $time, want.data, got.data);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: count mismatch: expected %0d, actual %0d",
                                 $time, want.count, got.count);
                        fail_count++;
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                due_responses.push_back(list_response(req_if.payload));
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("%0t: watchdog expired, %0d responses outstanding",
                             $time, due_responses.size());
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        send_gap_pct   = 38;
        take_gap_pct   = 51;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list
        queue_req(ial_pkg::MODE_READ, t_index'(0), '0);
        queue_req(ial_pkg::MODE_REMOVE, t_index'(0), '0);
        queue_req(ial_pkg::MODE_WRITE, t_index'(0), WORD_MAX);
        queue_req(ial_pkg::MODE_INSERT, t_index'(1), WORD_MIN);
        // insert at front, insert at count
        queue_req(ial_pkg::MODE_INSERT, t_index'(0), WORD_MIN);
        queue_req(ial_pkg::MODE_INSERT, t_index'(1), WORD_MAX);
        queue_req(ial_pkg::MODE_APPEND, '1, '1);
        while (plan_len < LIST_DEPTH - 1) begin
            queue_req(ial_pkg::MODE_APPEND, t_index'($urandom), t_word'($urandom));
        end
        // fill with a middle insert, then hit full
        queue_req(ial_pkg::MODE_INSERT, t_index'(7), '0);
        queue_req(ial_pkg::MODE_APPEND, t_index'(0), t_word'(1));
        queue_req(ial_pkg::MODE_INSERT, '1, t_word'(1));
        queue_req(ial_pkg::MODE_WRITE, '1, WORD_MIN);
        queue_req(ial_pkg::MODE_READ, '1, '0);
        queue_req(ial_pkg::MODE_REMOVE, t_index'(0), '0);
        queue_req(ial_pkg::MODE_REMOVE, t_index'(LIST_DEPTH - 2), '0);
        queue_req(MODE_FIRST_UNUSED, t_index'(0), '1);
        queue_req(MODE_LAST, '1, WORD_MAX);
        wait_drained();

        queue_random_phase(667);
        wait_drained();
        send_gap_pct = 51;
        take_gap_pct = 38;
        queue_random_phase(667);
        wait_drained();
        send_gap_pct = 0;
        take_gap_pct = 0;
        queue_random_phase(666);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
